>>> design/binary_max_heap_queue_assert.svh
// assertion macros used by the heap queue core
`ifndef BINARY_MAX_HEAP_QUEUE_ASSERT_SVH
`define BINARY_MAX_HEAP_QUEUE_ASSERT_SVH

// same-cycle implication
`define BMHQ_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bmhq assertion failed");

// next-cycle implication
`define BMHQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bmhq assertion failed");

`endif

>>> design/bmhq_pkg.sv
// ----------------------------------------------------------------------------
// bmhq_pkg
// Shared types and constants of the binary max-heap priority queue.
// ----------------------------------------------------------------------------
package bmhq_pkg;

   localparam int DEPTH_DEFAULT = 1024;
   localparam int VAL_W         = 32;
   localparam int CAP_W         = 11;
   localparam int COUNT_OUT_W   = 11;
   localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

   typedef enum logic {
      OP_INSERT  = 1'b0,
      OP_EXTRACT = 1'b1
   } bmhq_opcode_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2
   } bmhq_status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_UP_RD,
      ST_UP_CMP,
      ST_EX_ROOT,
      ST_EX_LAST,
      ST_EX_TAKE,
      ST_DN_RD_L,
      ST_DN_CMP_L,
      ST_DN_CMP_R,
      ST_DONE
   } bmhq_state_type;

   // memory port strobes
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } bmhq_mem_ctl_type;

   // one finished response
   typedef struct packed {
      bmhq_status_type         status;
      logic signed [VAL_W-1:0] max_value;
      logic [COUNT_OUT_W-1:0]  element_count;
      logic                    is_empty;
      logic                    is_full;
   } bmhq_result_type;

endpackage

>>> design/bmhq_req_if.sv
// ----------------------------------------------------------------------------
// bmhq_req_if
// Request channel of the heap queue: valid/ready with opcode and value.
// ----------------------------------------------------------------------------
interface bmhq_req_if;
   import bmhq_pkg::*;

   logic                    valid;
   logic                    ready;
   bmhq_opcode_type         opcode;
   logic signed [VAL_W-1:0] value;

   modport source (output valid, output opcode, output value, input ready);
   modport sink (input valid, input opcode, input value, output ready);

endinterface

>>> design/bmhq_rsp_if.sv
// ----------------------------------------------------------------------------
// bmhq_rsp_if
// Response channel of the heap queue: valid/ready with status and flags.
// ----------------------------------------------------------------------------
interface bmhq_rsp_if;
   import bmhq_pkg::*;

   logic                    valid;
   logic                    ready;
   bmhq_status_type         status;
   logic signed [VAL_W-1:0] max_value;
   logic [COUNT_OUT_W-1:0]  element_count;
   logic                    is_empty;
   logic                    is_full;

   modport source (output valid, output status, output max_value,
                   output element_count, output is_empty, output is_full,
                   input ready);
   modport sink (input valid, input status, input max_value,
                 input element_count, input is_empty, input is_full,
                 output ready);

endinterface

>>> design/binary_max_heap_queue.sv
// ----------------------------------------------------------------------------
// binary_max_heap_queue
// Priority queue of signed 32-bit values held as an array-backed max-heap.
//
//   channel   dir   handshake       payload
//   req_if    in    valid/ready     opcode, value
//   rsp_if    out   valid/ready     status, max_value, element_count,
//                                   is_empty, is_full
//   csr       in    write enable    capacity_limit (11 bits)
//
// An insert places the value at the next free slot and moves it up a level per step;
// an extract reads the root and the last element, then moves the last element down
// a level per step, so the work grows with the number of levels the value moves;
// a refused request goes straight to the response.
// The single read port of the heap memory and the shared comparator set
// the per-level cost. A new request is taken once the previous response sits
// in the output register. Reset is synchronous; the heap memory needs no clear.
// ----------------------------------------------------------------------------
module binary_max_heap_queue #(
   parameter int DEPTH = bmhq_pkg::DEPTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   bmhq_req_if.sink                    req_if,
   bmhq_rsp_if.source                  rsp_if,
   input  logic                        csr_write_en,
   input  logic [bmhq_pkg::CAP_W-1:0]  csr_write_data
);
   import bmhq_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);

   logic [CAP_W-1:0]        capacity_ff, capacity_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   bmhq_result_type         rsp_data_ff, rsp_data_in;

   logic                    out_free;
   logic                    done;
   bmhq_result_type         result;
   bmhq_mem_ctl_type        mem_ctl;
   logic [IDX_W-1:0]        mem_waddr;
   logic signed [VAL_W-1:0] mem_wdata;
   logic [IDX_W-1:0]        mem_raddr;
   logic signed [VAL_W-1:0] mem_rdata;

   // capacity register
   assign capacity_in = csr_write_en ? csr_write_data : capacity_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   // sequencer
   bmhq_core #(
      .DEPTH (DEPTH)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .capacity  (capacity_ff),
      .out_free  (out_free),
      .done      (done),
      .result    (result),
      .mem_ctl   (mem_ctl),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata)
   );

   // heap storage
   bmhq_mem #(
      .DEPTH (DEPTH)
   ) u_mem (
      .clock (clock),
      .ctl   (mem_ctl),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   // output register
   assign out_free     = !rsp_valid_ff || rsp_if.ready;
   assign rsp_valid_in = (done && out_free) || (rsp_valid_ff && !rsp_if.ready);
   assign rsp_data_in  = (done && out_free) ? result : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   // response channel
   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.status        = rsp_data_ff.status;
   assign rsp_if.max_value     = rsp_data_ff.max_value;
   assign rsp_if.element_count = rsp_data_ff.element_count;
   assign rsp_if.is_empty      = rsp_data_ff.is_empty;
   assign rsp_if.is_full       = rsp_data_ff.is_full;

endmodule

>>> design/bmhq_mem.sv
// ----------------------------------------------------------------------------
// bmhq_mem
// Heap storage: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bmhq_mem #(
   parameter int DEPTH = bmhq_pkg::DEPTH_DEFAULT
) (
   input  logic                               clock,
   input  bmhq_pkg::bmhq_mem_ctl_type         ctl,
   input  logic [$clog2(DEPTH)-1:0]           waddr,
   input  logic signed [bmhq_pkg::VAL_W-1:0]  wdata,
   input  logic [$clog2(DEPTH)-1:0]           raddr,
   output logic signed [bmhq_pkg::VAL_W-1:0]  rdata
);
   import bmhq_pkg::*;

   logic signed [VAL_W-1:0] mem [DEPTH];
   logic signed [VAL_W-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[waddr] <= wdata;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> design/bmhq_core.sv
// ----------------------------------------------------------------------------
// bmhq_core
// Sequencer of the heap: sift up and sift down through one shared signed
// comparator and the single-read heap memory, one level per step.
// ----------------------------------------------------------------------------
module bmhq_core #(
   parameter int DEPTH = bmhq_pkg::DEPTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   bmhq_req_if.sink                           req_if,
   input  logic [bmhq_pkg::CAP_W-1:0]         capacity,
   input  logic                               out_free,
   output logic                               done,
   output bmhq_pkg::bmhq_result_type          result,
   output bmhq_pkg::bmhq_mem_ctl_type         mem_ctl,
   output logic [$clog2(DEPTH)-1:0]           mem_waddr,
   output logic signed [bmhq_pkg::VAL_W-1:0]  mem_wdata,
   output logic [$clog2(DEPTH)-1:0]           mem_raddr,
   input  logic signed [bmhq_pkg::VAL_W-1:0]  mem_rdata
);
   import bmhq_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CH_W  = CNT_W + 1;
   localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   bmhq_state_type          state_ff, state_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [IDX_W-1:0]        pos_ff, pos_in;
   logic signed [VAL_W-1:0] carry_ff, carry_in;
   logic signed [VAL_W-1:0] best_ff, best_in;
   logic [IDX_W-1:0]        best_idx_ff, best_idx_in;
   logic                    best_child_ff, best_child_in;
   logic signed [VAL_W-1:0] max_ff, max_in;
   bmhq_status_type         status_ff, status_in;

   logic                    req_fire;
   logic [CMP_W-1:0]        cap_ext;
   logic [CMP_W-1:0]        eff_cap;
   logic                    full_now;
   logic [IDX_W-1:0]        parent;
   logic [CH_W-1:0]         child_l;
   logic [CH_W-1:0]         child_r;
   logic                    l_ok;
   logic                    r_ok;
   logic signed [VAL_W-1:0] cmp_a;
   logic signed [VAL_W-1:0] cmp_b;
   logic                    cmp_gt;
   logic                    core_busy;
   logic                    insert_go;

   assign req_fire = req_if.valid && req_if.ready;

   // effective capacity saturates at the memory depth
   assign cap_ext  = CMP_W'(capacity);
   assign eff_cap  = (cap_ext > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : cap_ext;
   assign full_now = CMP_W'(count_ff) >= eff_cap;

   // tree navigation
   assign parent  = IDX_W'((pos_ff - IDX_W'(1)) >> 1);
   assign child_l = CH_W'({pos_ff, 1'b1});
   assign child_r = CH_W'({pos_ff, 1'b0}) + CH_W'(2);
   assign l_ok    = child_l < CH_W'(count_ff);
   assign r_ok    = child_r < CH_W'(count_ff);

   // shared signed comparator, operands picked by step
   always_comb begin
      cmp_a = mem_rdata;
      cmp_b = carry_ff;
      unique case (state_ff)
         ST_UP_CMP: begin
            cmp_a = carry_ff;
            cmp_b = mem_rdata;
         end
         ST_DN_CMP_R: begin
            cmp_a = mem_rdata;
            cmp_b = best_ff;
         end
         default: begin
            cmp_a = mem_rdata;
            cmp_b = carry_ff;
         end
      endcase
   end

   assign cmp_gt = cmp_a > cmp_b;

   // state and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      carry_ff      <= carry_in;
      best_ff       <= best_in;
      best_idx_ff   <= best_idx_in;
      best_child_ff <= best_child_in;
      max_ff        <= max_in;
      status_ff     <= status_in;
   end

   // next state and memory strobes
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      carry_in      = carry_ff;
      best_in       = best_ff;
      best_idx_in   = best_idx_ff;
      best_child_in = best_child_ff;
      max_in        = max_ff;
      status_in     = status_ff;
      mem_ctl       = '0;
      mem_waddr     = pos_ff;
      mem_wdata     = carry_ff;
      mem_raddr     = parent;
      req_if.ready  = 1'b0;
      done          = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_if.ready = 1'b1;
            if (req_if.valid) begin
               max_in    = '0;
               status_in = STAT_OK;
               if (req_if.opcode == OP_INSERT) begin
                  if (full_now) begin
                     status_in = STAT_FULL;
                     state_in  = ST_DONE;
                  end else begin
                     carry_in = req_if.value;
                     pos_in   = IDX_W'(count_ff);
                     count_in = count_ff + CNT_W'(1);
                     state_in = ST_UP_RD;
                  end
               end else begin
                  if (count_ff == '0) begin
                     status_in = STAT_EMPTY;
                     state_in  = ST_DONE;
                  end else begin
                     state_in = ST_EX_ROOT;
                  end
               end
            end
         end

         // sift up: fetch parent or settle at the root
         ST_UP_RD: begin
            if (pos_ff == '0) begin
               mem_ctl.wr_en = 1'b1;
               state_in      = ST_DONE;
            end else begin
               mem_ctl.rd_en = 1'b1;
               mem_raddr     = parent;
               state_in      = ST_UP_CMP;
            end
         end

         // move parent down into the hole or drop the new value in
         ST_UP_CMP: begin
            mem_ctl.wr_en = 1'b1;
            if (cmp_gt) begin
               mem_wdata = mem_rdata;
               pos_in    = parent;
               state_in  = ST_UP_RD;
            end else begin
               state_in = ST_DONE;
            end
         end

         // extract: fetch root, then last element
         ST_EX_ROOT: begin
            mem_ctl.rd_en = 1'b1;
            mem_raddr     = '0;
            state_in      = ST_EX_LAST;
         end

         ST_EX_LAST: begin
            max_in        = mem_rdata;
            mem_ctl.rd_en = 1'b1;
            mem_raddr     = IDX_W'(count_ff - CNT_W'(1));
            state_in      = ST_EX_TAKE;
         end

         ST_EX_TAKE: begin
            carry_in = mem_rdata;
            count_in = count_ff - CNT_W'(1);
            pos_in   = '0;
            state_in = ST_DN_RD_L;
         end

         // sift down: fetch left child or settle
         ST_DN_RD_L: begin
            if (l_ok) begin
               mem_ctl.rd_en = 1'b1;
               mem_raddr     = IDX_W'(child_l);
               state_in      = ST_DN_CMP_L;
            end else begin
               mem_ctl.wr_en = 1'b1;
               state_in      = ST_DONE;
            end
         end

         // left child against the moving value, fetch right child
         ST_DN_CMP_L: begin
            if (cmp_gt) begin
               best_in       = mem_rdata;
               best_idx_in   = IDX_W'(child_l);
               best_child_in = 1'b1;
            end else begin
               best_in       = carry_ff;
               best_child_in = 1'b0;
            end
            if (r_ok) begin
               mem_ctl.rd_en = 1'b1;
               mem_raddr     = IDX_W'(child_r);
            end
            state_in = ST_DN_CMP_R;
         end

         // right child against the best so far, then move or settle
         ST_DN_CMP_R: begin
            mem_ctl.wr_en = 1'b1;
            if (r_ok && cmp_gt) begin
               mem_wdata = mem_rdata;
               pos_in    = IDX_W'(child_r);
               state_in  = ST_DN_RD_L;
            end else if (best_child_ff) begin
               mem_wdata = best_ff;
               pos_in    = best_idx_ff;
               state_in  = ST_DN_RD_L;
            end else begin
               state_in = ST_DONE;
            end
         end

         // hand the response over once the output slot is free
         ST_DONE: begin
            done = 1'b1;
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // response fields
   always_comb begin
      result.status        = status_ff;
      result.max_value     = max_ff;
      result.element_count = COUNT_OUT_W'(count_ff);
      result.is_empty      = count_ff == '0;
      result.is_full       = full_now;
   end

   // assertion helpers
   assign core_busy = (state_ff != ST_IDLE) && (state_ff != ST_DONE);
   assign insert_go = req_fire && (req_if.opcode == OP_INSERT) && !full_now;

   `include "binary_max_heap_queue_assert.svh"

   `BMHQ_ASSERT_NOW(a_count_range, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH))
   `BMHQ_ASSERT_NOW(a_write_busy, clock, reset, mem_ctl.wr_en, core_busy)
   `BMHQ_ASSERT_NEXT(a_accept_busy, clock, reset, req_fire, state_ff != ST_IDLE)
   `BMHQ_ASSERT_NEXT(a_insert_count, clock, reset, insert_go, count_ff == $past(count_ff) + CNT_W'(1))

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the binary max-heap priority queue. A directed
// table covers the value extremes, both operations, equal values and the
// capacity corner cases. Random load phases follow, one of them filling the
// heap to its depth. Every response is checked against the table's expected values or a local heap model.
// ----------------------------------------------------------------------------
module testbench;
   import bmhq_pkg::*;

   localparam int HEAP_DEPTH  = DEPTH_DEFAULT;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_WAIT  = 40;

   typedef enum logic {
      ROW_REQUEST,
      ROW_CAPACITY
   } row_kind_type;

   typedef struct {
      row_kind_type            kind;
      bmhq_opcode_type         op;
      logic signed [VAL_W-1:0] value;
      logic [CAP_W-1:0]        capacity;
      bit                      typed;
      bmhq_result_type         result;
   } stim_row_type;

   typedef struct {
      logic [CAP_W-1:0] capacity;
      int               length;
      int               insert_pct;
      bit               fill_first;
   } load_phase_type;

   logic             clock = 1'b0;
   logic             reset;
   logic             csr_write_en;
   logic [CAP_W-1:0] csr_write_data;

   bmhq_req_if req_bus ();
   bmhq_rsp_if rsp_bus ();

   binary_max_heap_queue #(
      .DEPTH(HEAP_DEPTH)
   ) u_top (
      .clock         (clock),
      .reset         (reset),
      .req_if        (req_bus),
      .rsp_if        (rsp_bus),
      .csr_write_en  (csr_write_en),
      .csr_write_data(csr_write_data)
   );

   // heap model state
   logic signed [VAL_W-1:0] heap_model [HEAP_DEPTH];
   int                      model_count = 0;
   logic [CAP_W-1:0]        model_cap = CAP_RESET;

   bmhq_result_type pending_rsp_q [$];
   int              error_count = 0;
   int              cycle_count = 0;
   int              burst_left = 0;
   int              mode_left = 0;
   logic [1:0]      rsp_mode = 2'd0;

   always #1 clock = ~clock;

   function automatic int model_capacity();
      return (int'(model_cap) > HEAP_DEPTH) ? HEAP_DEPTH : int'(model_cap);
   endfunction

   // apply one request to the heap model and return its response
   function automatic bmhq_result_type heap_model_step(bmhq_opcode_type op,
                                                        logic signed [VAL_W-1:0] val);
      bmhq_result_type         res;
      logic signed [VAL_W-1:0] tmp;
      int                      i;
      int                      p;
      int                      l;
      int                      r;
      int                      big;
      res = '0;
      res.status = STAT_OK;
      if (op == OP_INSERT) begin
         if (model_count >= model_capacity()) begin
            res.status = STAT_FULL;
         end else begin
            heap_model[model_count] = val;
            model_count++;
            // sift up while strictly larger than the parent
            i = model_count - 1;
            while (i > 0) begin
               p = (i - 1) / 2;
               if (!(heap_model[i] > heap_model[p])) break;
               tmp = heap_model[p];
               heap_model[p] = heap_model[i];
               heap_model[i] = tmp;
               i = p;
            end
         end
      end else begin
         if (model_count == 0) begin
            res.status = STAT_EMPTY;
         end else begin
            res.max_value = heap_model[0];
            heap_model[0] = heap_model[model_count - 1];
            model_count--;
            // sift down toward the larger child, left wins a tie
            i = 0;
            forever begin
               l = 2 * i + 1;
               r = 2 * i + 2;
               big = i;
               if (l < model_count && heap_model[l] > heap_model[big]) big = l;
               if (r < model_count && heap_model[r] > heap_model[big]) big = r;
               if (big == i) break;
               tmp = heap_model[i];
               heap_model[i] = heap_model[big];
               heap_model[big] = tmp;
               i = big;
            end
         end
      end
      res.element_count = model_count[COUNT_OUT_W-1:0];
      res.is_empty      = (model_count == 0);
      res.is_full       = (model_count >= model_capacity());
      return res;
   endfunction

   // directed table row builders
   function automatic stim_row_type req_row(bmhq_opcode_type op,
                                            logic signed [VAL_W-1:0] val);
      stim_row_type row;
      row = '{ROW_REQUEST, op, val, '0, 1'b0, '0};
      return row;
   endfunction

   function automatic stim_row_type req_check(bmhq_opcode_type op,
                                              logic signed [VAL_W-1:0] val,
                                              bmhq_status_type st,
                                              logic signed [VAL_W-1:0] maxv,
                                              int cnt, bit emp, bit full);
      stim_row_type row;
      row = req_row(op, val);
      row.typed                = 1'b1;
      row.result.status        = st;
      row.result.max_value     = maxv;
      row.result.element_count = cnt[COUNT_OUT_W-1:0];
      row.result.is_empty      = emp;
      row.result.is_full       = full;
      return row;
   endfunction

   function automatic stim_row_type cap_row(logic [CAP_W-1:0] cap);
      stim_row_type row;
      row = '{ROW_CAPACITY, OP_INSERT, '0, cap, 1'b0, '0};
      return row;
   endfunction

   // value mix: extremes, a narrow band for duplicates, full range
   function automatic logic signed [VAL_W-1:0] pick_value();
      logic signed [VAL_W-1:0] v;
      case ($urandom_range(0, 7))
         0: v = 32'sh7fff_ffff;
         1: v = 32'sh8000_0000;
         2, 3: v = 32'($urandom_range(0, 16)) - 32'sd8;
         default: v = $urandom;
      endcase
      return v;
   endfunction

   task automatic hold_off(int cycles);
      req_bus.valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // sender bursts with random gaps, gap of zero keeps the stream solid
   task automatic pace_sender();
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) hold_off(gap);
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
   endtask

   // drive one request and queue its response once accepted
   task automatic send_request(bmhq_opcode_type op, logic signed [VAL_W-1:0] val,
                               bit typed, bmhq_result_type typed_res);
      bmhq_result_type predicted;
      req_bus.valid  <= 1'b1;
      req_bus.opcode <= op;
      req_bus.value  <= val;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predicted = heap_model_step(op, val);
      pending_rsp_q.push_back(typed ? typed_res : predicted);
   endtask

   // capacity writes only once every response is back
   task automatic write_capacity(logic [CAP_W-1:0] cap);
      hold_off(2);
      while (pending_rsp_q.size() != 0) @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= cap;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      model_cap = cap;
   endtask

   task automatic random_request(int insert_pct);
      bmhq_opcode_type op;
      op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_EXTRACT;
      pace_sender();
      send_request(op, pick_value(), 1'b0, '0);
   endtask

   // receiver stall pattern, with a random mode that is redrawn when its countdown runs out
   always @(posedge clock) begin
      if (mode_left == 0) begin
         rsp_mode  <= 2'($urandom_range(0, 3));
         mode_left <= $urandom_range(32, 256);
      end else begin
         mode_left <= mode_left - 1;
      end
      case (rsp_mode)
         2'd0: rsp_bus.ready <= 1'b1;
         2'd1: rsp_bus.ready <= 1'($urandom_range(0, 1));
         2'd2: rsp_bus.ready <= (mode_left % 4 == 0);
         default: rsp_bus.ready <= ($urandom_range(0, 9) == 0);
      endcase
   end

   function automatic void flag_field(string field, longint want, longint got);
      error_count++;
      if (error_count <= 10)
         $display("response %s: expected %0h, got %0h", field, want, got);
   endfunction

   // response checker
   always @(posedge clock) begin
      bmhq_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_rsp_q.size() == 0) begin
            error_count++;
            if (error_count <= 10) $display("response with no request pending");
         end else begin
            want = pending_rsp_q.pop_front();
            if (rsp_bus.status !== want.status)
               flag_field("status", want.status, rsp_bus.status);
            if (rsp_bus.max_value !== want.max_value)
               flag_field("max_value", want.max_value, rsp_bus.max_value);
            if (rsp_bus.element_count !== want.element_count)
               flag_field("element_count", want.element_count, rsp_bus.element_count);
            if (rsp_bus.is_empty !== want.is_empty)
               flag_field("is_empty", want.is_empty, rsp_bus.is_empty);
            if (rsp_bus.is_full !== want.is_full)
               flag_field("is_full", want.is_full, rsp_bus.is_full);
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("binary_max_heap_queue: mismatch");
         $finish;
      end
   end

   initial begin
      stim_row_type   stim_rows [$];
      load_phase_type phases [$];
      req_bus.valid  <= 1'b0;
      req_bus.opcode <= OP_INSERT;
      req_bus.value  <= '0;
      csr_write_en   <= 1'b0;
      csr_write_data <= '0;
      reset          <= 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed part: extremes, equal values, capacity corners
      stim_rows = '{
         req_check(OP_EXTRACT, 32'sh1234_5678, STAT_EMPTY, 0, 0, 1, 0),
         req_check(OP_INSERT, 32'sh7fff_ffff, STAT_OK, 0, 1, 0, 0),
         req_check(OP_INSERT, 32'sh8000_0000, STAT_OK, 0, 2, 0, 0),
         req_row(OP_INSERT, -32'sd1),
         req_check(OP_EXTRACT, 32'shffff_ffff, STAT_OK, 32'sh7fff_ffff, 2, 0, 0),
         req_row(OP_EXTRACT, 32'sh0),
         req_check(OP_EXTRACT, 32'sh0, STAT_OK, 32'sh8000_0000, 0, 1, 0),
         req_row(OP_INSERT, 32'sd7),
         req_row(OP_INSERT, 32'sd7),
         req_row(OP_INSERT, 32'sd7),
         req_row(OP_INSERT, 32'sh5555_5555),
         req_row(OP_INSERT, 32'shaaaa_aaaa),
         req_row(OP_EXTRACT, 32'sh5555_5555),
         req_row(OP_EXTRACT, 32'shaaaa_aaaa),
         req_row(OP_EXTRACT, 32'sh0),
         // capacity dropped below the stored count
         cap_row(11'd1),
         req_check(OP_INSERT, 32'sd3, STAT_FULL, 0, 2, 0, 1),
         req_row(OP_EXTRACT, 32'sh0),
         req_row(OP_EXTRACT, 32'sh0),
         req_check(OP_INSERT, 32'sd3, STAT_OK, 0, 1, 0, 1),
         // zero capacity, full from the start
         cap_row(11'd0),
         req_check(OP_INSERT, 32'sd9, STAT_FULL, 0, 1, 0, 1),
         req_check(OP_EXTRACT, 32'sh0, STAT_OK, 32'sd3, 0, 1, 1),
         req_check(OP_EXTRACT, 32'sh0, STAT_EMPTY, 0, 0, 1, 1),
         // capacity above depth saturates
         cap_row(11'd2047),
         req_check(OP_INSERT, 32'sh0, STAT_OK, 0, 1, 0, 0),
         req_check(OP_EXTRACT, 32'sh0, STAT_OK, 0, 0, 1, 0)
      };
      foreach (stim_rows[n]) begin
         if (stim_rows[n].kind == ROW_CAPACITY) begin
            write_capacity(stim_rows[n].capacity);
         end else begin
            pace_sender();
            send_request(stim_rows[n].op, stim_rows[n].value,
                         stim_rows[n].typed, stim_rows[n].result);
         end
      end

      // random load phases, one of them fills the heap to its depth
      phases = '{
         '{11'd16, 200, 60, 1'b0},
         '{11'd1, 80, 50, 1'b0},
         '{11'd0, 40, 50, 1'b0},
         '{11'($urandom_range(2, 64)), 200, 55, 1'b0},
         '{11'd2047, 30, 95, 1'b1},
         '{11'd7, 200, 40, 1'b0},
         '{CAP_RESET, 100, 50, 1'b0}
      };
      foreach (phases[n]) begin
         write_capacity(phases[n].capacity);
         if (phases[n].fill_first) begin
            while (model_count < model_capacity()) random_request(phases[n].insert_pct);
         end
         repeat (phases[n].length) random_request(phases[n].insert_pct);
      end

      // drain and finish
      hold_off(1);
      while (pending_rsp_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0) begin
         $display("binary_max_heap_queue: match");
      end else begin
         $display("binary_max_heap_queue: mismatch");
      end
      $finish;
   end

endmodule
